@@ hw/rtl/epoch_seconds_to_calendar_top_macros.svh @@
// Assertion macros for the epoch seconds to calendar converter.
// Included by the top level; no other dependencies.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esc assertion failed");
`define ESC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esc assertion failed");
`else
`define ESC_ASSERT_IMP(label, clk, rst, ante, cons)
`define ESC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/esc_pkg.sv @@
// Shared constants and calendar helper functions for the epoch converter.
// No dependencies.
`default_nettype none
package esc_pkg;

  localparam int unsigned SecondsW = 6;
  localparam int unsigned MinutesW = 6;
  localparam int unsigned HoursW   = 5;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned YearW    = 8;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned EpochW   = 32;
  localparam int unsigned DaysW    = 16;

  localparam logic [5:0] SecsPerMin   = 6'd60;
  localparam logic [5:0] MinsPerHour  = 6'd60;
  localparam logic [5:0] HoursPerDay  = 6'd24;
  localparam logic [5:0] DaysPerWeek  = 6'd7;

  // year offset 130 is 2100: divisible by 4 but not a leap year
  localparam logic [YearW-1:0] CenturySkipOff = 8'd130;
  localparam logic [MonthW-1:0] LastMonthIdx  = 4'd11;
  localparam logic [MonthW-1:0] FebIdx        = 4'd1;

  function automatic logic is_leap(input logic [YearW-1:0] year_off);
    return (year_off[1:0] == 2'd2) && (year_off != CenturySkipOff);
  endfunction

  function automatic logic [8:0] year_len(input logic [YearW-1:0] year_off);
    return is_leap(year_off) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [MonthW-1:0] idx,
                                           input logic leap);
    logic [4:0] len;
    case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days mod 7 to weekday; the epoch fell on a Thursday
  function automatic logic [WeekdayW-1:0] weekday_of(input logic [2:0] r);
    logic [WeekdayW-1:0] wd;
    case (r)
      3'd0:    wd = 3'd5;
      3'd1:    wd = 3'd6;
      3'd2:    wd = 3'd7;
      3'd3:    wd = 3'd1;
      3'd4:    wd = 3'd2;
      3'd5:    wd = 3'd3;
      3'd6:    wd = 3'd4;
      default: wd = 3'd1;
    endcase
    return wd;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/esc_if.sv @@
// Valid/ready channel interfaces for the epoch converter.
// Depends on esc_pkg.
`default_nettype none
interface esc_in_if;
  logic                         valid;
  logic                         ready;
  logic [esc_pkg::EpochW-1:0]   epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
  logic                           valid;
  logic                           ready;
  logic [esc_pkg::SecondsW-1:0]   second_of_minute;
  logic [esc_pkg::MinutesW-1:0]   minute_of_hour;
  logic [esc_pkg::HoursW-1:0]     hour_of_day;
  logic [esc_pkg::WeekdayW-1:0]   weekday;
  logic [esc_pkg::YearW-1:0]      year_offset;
  logic [esc_pkg::MonthW-1:0]     month_number;
  logic [esc_pkg::DayW-1:0]       day_of_month;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output weekday, output year_offset,
                  output month_number, output day_of_month, input ready);
  modport sink   (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input weekday, input year_offset,
                  input month_number, input day_of_month, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/epoch_seconds_to_calendar_top.sv @@
// Handles one item at a time, from accepted transaction to result valid.
// First /60, /60, /24 and mod 7, each a reciprocal multiply, a multiply back and a
// subtract on one shared multiplier and subtractor; then whole years are subtracted, then
// whole months. Ready again the cycle after the result transaction.
// Reset (synchronous, rst high) returns to idle and drops any pending result.
// Depends on esc_pkg, esc_if and epoch_seconds_to_calendar_top_macros.svh.
`default_nettype none
`include "epoch_seconds_to_calendar_top_macros.svh"
module epoch_seconds_to_calendar_top (
  input  wire logic clk,
  input  wire logic rst,
  esc_in_if.sink    din,
  esc_out_if.source dout
);

  typedef enum logic [2:0] {
    S_IDLE, S_MULQ, S_MULR, S_REM, S_YEAR, S_MONTH, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_SEC, P_MIN, P_HOUR, P_WDAY
  } pass_t;

  // floor(x / d) = (x * recip) >> shift over each pass's operand range
  localparam logic [esc_pkg::EpochW-1:0] RecipBy60 = 32'h8888_8889;  // >> 37
  localparam logic [esc_pkg::EpochW-1:0] RecipBy24 = 32'hAAAA_AAAB;  // >> 36
  localparam logic [esc_pkg::EpochW-1:0] RecipBy7  = 32'h2492_4925;  // >> 32, below 2^17

  state_t                        state;
  pass_t                         pass;
  logic [esc_pkg::EpochW-1:0]    opnd;
  logic [esc_pkg::EpochW-1:0]    quo;
  logic [2*esc_pkg::EpochW-1:0]  prod;
  logic [esc_pkg::DaysW-1:0]     days;
  logic [esc_pkg::YearW-1:0]     year;
  logic [esc_pkg::MonthW-1:0]    month;
  logic [esc_pkg::SecondsW-1:0]  sec;
  logic [esc_pkg::MinutesW-1:0]  min;
  logic [esc_pkg::HoursW-1:0]    hour;
  logic [esc_pkg::WeekdayW-1:0]  wday;

  // shared multiplier
  logic [esc_pkg::EpochW-1:0]    mul_a;
  logic [esc_pkg::EpochW-1:0]    mul_b;
  logic [2*esc_pkg::EpochW-1:0]  mul_p;
  logic [esc_pkg::EpochW-1:0]    quot;
  logic [esc_pkg::EpochW-1:0]    recip;
  logic [5:0]                    divisor;

  // shared compare/subtract unit
  logic [esc_pkg::DaysW-1:0]     sub_a;
  logic [esc_pkg::DaysW-1:0]     sub_b;
  logic [esc_pkg::DaysW:0]       diff;
  logic                          ge;
  logic                          leap;

  assign leap = esc_pkg::is_leap(year);

  always_comb begin
    quot    = prod[63:32];
    recip   = RecipBy7;
    divisor = esc_pkg::DaysPerWeek;
    case (pass)
      P_SEC: begin
        quot    = {5'd0, prod[63:37]};
        recip   = RecipBy60;
        divisor = esc_pkg::SecsPerMin;
      end
      P_MIN: begin
        quot    = {5'd0, prod[63:37]};
        recip   = RecipBy60;
        divisor = esc_pkg::MinsPerHour;
      end
      P_HOUR: begin
        quot    = {4'd0, prod[63:36]};
        recip   = RecipBy24;
        divisor = esc_pkg::HoursPerDay;
      end
      default: ;
    endcase
  end

  assign mul_a = (state == S_MULR) ? quot : opnd;
  assign mul_b = (state == S_MULR) ? {26'd0, divisor} : recip;
  // 32 x 32 product
  assign mul_p = {{esc_pkg::EpochW{1'b0}}, mul_a} * {{esc_pkg::EpochW{1'b0}}, mul_b};

  always_comb begin
    // remainder: low bits of operand minus quotient times divisor
    sub_a = opnd[esc_pkg::DaysW-1:0];
    sub_b = prod[esc_pkg::DaysW-1:0];
    case (state)
      S_YEAR: begin
        sub_a = days;
        sub_b = {7'd0, esc_pkg::year_len(year)};
      end
      S_MONTH: begin
        sub_a = days;
        sub_b = {11'd0, esc_pkg::month_len(month, leap)};
      end
      default: ;
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = !diff[esc_pkg::DaysW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (din.valid) begin
            opnd  <= din.epoch_seconds;
            pass  <= P_SEC;
            state <= S_MULQ;
          end
        end
        S_MULQ: begin
          prod  <= mul_p;
          state <= S_MULR;
        end
        S_MULR: begin
          quo   <= quot;
          prod  <= mul_p;
          state <= S_REM;
        end
        S_REM: begin
          case (pass)
            P_SEC: begin
              sec   <= diff[esc_pkg::SecondsW-1:0];
              opnd  <= quo;
              pass  <= P_MIN;
              state <= S_MULQ;
            end
            P_MIN: begin
              min   <= diff[esc_pkg::MinutesW-1:0];
              opnd  <= quo;
              pass  <= P_HOUR;
              state <= S_MULQ;
            end
            P_HOUR: begin
              hour  <= diff[esc_pkg::HoursW-1:0];
              days  <= quo[esc_pkg::DaysW-1:0];
              opnd  <= quo;
              pass  <= P_WDAY;
              state <= S_MULQ;
            end
            default: begin
              wday  <= esc_pkg::weekday_of(diff[2:0]);
              year  <= '0;
              state <= S_YEAR;
            end
          endcase
        end
        S_YEAR: begin
          if (ge) begin
            days <= diff[esc_pkg::DaysW-1:0];
            year <= year + 8'd1;
          end else begin
            month <= '0;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (ge && month != esc_pkg::LastMonthIdx) begin
            days  <= diff[esc_pkg::DaysW-1:0];
            month <= month + 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (dout.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign din.ready              = (state == S_IDLE);
  assign dout.valid             = (state == S_DONE);
  assign dout.second_of_minute  = sec;
  assign dout.minute_of_hour    = min;
  assign dout.hour_of_day       = hour;
  assign dout.weekday           = wday;
  assign dout.year_offset       = year;
  assign dout.month_number      = month + 4'd1;
  assign dout.day_of_month      = days[esc_pkg::DayW-1:0] + 5'd1;

  `ESC_ASSERT_NXT(a_busy_after_accept, clk, rst, din.valid && din.ready, !din.ready && !dout.valid)
  `ESC_ASSERT_IMP(a_result_range, clk, rst, dout.valid, (sec < 6'd60) && (min < 6'd60) && (hour < 5'd24) && (wday != 3'd0) && (month <= esc_pkg::LastMonthIdx))
  `ESC_ASSERT_IMP(a_year_bound, clk, rst, state == S_YEAR, year <= 8'd136)
  `ESC_ASSERT_IMP(a_month_days, clk, rst, state == S_MONTH, days < 16'd366)
  `ESC_ASSERT_NXT(a_idle_after_out, clk, rst, dout.valid && dout.ready, din.ready)

endmodule
`default_nettype wire

@@ dv/epoch_seconds_to_calendar_check.sv @@
// Calendar check: watches both channels, works out the calendar breakdown of every
// accepted epoch transaction and compares it with each result transaction in order.
// Depends on esc_pkg and esc_if.
module epoch_seconds_to_calendar_check (
  input  logic        clk,
  input  logic        rst,
  esc_in_if           din,
  esc_out_if          dout,
  output int unsigned fails,
  output int unsigned pending
);

  typedef struct packed {
    logic [esc_pkg::SecondsW-1:0] sec;
    logic [esc_pkg::MinutesW-1:0] min;
    logic [esc_pkg::HoursW-1:0]   hour;
    logic [esc_pkg::WeekdayW-1:0] wday;
    logic [esc_pkg::YearW-1:0]    year_off;
    logic [esc_pkg::MonthW-1:0]   month;
    logic [esc_pkg::DayW-1:0]     mday;
  } calendar_t;

  calendar_t due_q[$];

  function automatic bit gregorian_leap(input int unsigned year);
    return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
    if (month == 2) return leap ? 29 : 28;
    if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
    return 31;
  endfunction

  function automatic calendar_t calendar_of(input logic [esc_pkg::EpochW-1:0] secs);
    int unsigned t;
    int unsigned days;
    int unsigned year;
    int unsigned month;
    bit          leap;
    calendar_t   c;
    t      = secs;
    c.sec  = 6'(t % 60);
    t      = t / 60;
    c.min  = 6'(t % 60);
    t      = t / 60;
    c.hour = 5'(t % 24);
    days   = t / 24;
    // 1970-01-01 was a Thursday
    c.wday = 3'(((days + 4) % 7) + 1);
    year   = 1970;
    while (days >= (gregorian_leap(year) ? 366 : 365)) begin
      days = days - (gregorian_leap(year) ? 366 : 365);
      year++;
    end
    leap  = gregorian_leap(year);
    month = 1;
    while (month < 12 && days >= days_in_month(month, leap)) begin
      days = days - days_in_month(month, leap);
      month++;
    end
    c.year_off = 8'(year - 1970);
    c.month    = 4'(month);
    c.mday     = 5'(days + 1);
    return c;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (!rst) begin
      if (din.valid && din.ready)
        due_q.push_back(calendar_of(din.epoch_seconds));
      if (dout.valid && dout.ready) begin
        if (due_q.size() == 0) begin
          report("result transaction with nothing outstanding");
        end else begin
          want = due_q.pop_front();
          check_field("second_of_minute", 32'(dout.second_of_minute), 32'(want.sec));
          check_field("minute_of_hour",   32'(dout.minute_of_hour),   32'(want.min));
          check_field("hour_of_day",      32'(dout.hour_of_day),      32'(want.hour));
          check_field("weekday",          32'(dout.weekday),          32'(want.wday));
          check_field("year_offset",      32'(dout.year_offset),      32'(want.year_off));
          check_field("month_number",     32'(dout.month_number),     32'(want.month));
          check_field("day_of_month",     32'(dout.day_of_month),     32'(want.mday));
        end
      end
      pending <= due_q.size();
    end
  end

endmodule

@@ dv/epoch_seconds_to_calendar_top_test.sv @@
// Testbench top for the epoch seconds to calendar converter: clock, reset, stimulus
// with random idling on both sides, and the verdict. Depends on esc_pkg, esc_if,
// epoch_seconds_to_calendar_top and epoch_seconds_to_calendar_check.
module epoch_seconds_to_calendar_top_test;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned HoldCycles  = 900;
  localparam int unsigned PhaseItems  = 445;
  localparam int unsigned SecsPerDay  = 86400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fails;
  int unsigned pending;
  int unsigned cycles = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;

  esc_in_if  din ();
  esc_out_if dout ();

  epoch_seconds_to_calendar_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  epoch_seconds_to_calendar_check calendar_check (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .dout    (dout),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= HoldCycles;
      dout.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_epoch(input logic [esc_pkg::EpochW-1:0] secs);
    while ($urandom_range(99) < tx_idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid         <= 1'b1;
    din.epoch_seconds <= secs;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [esc_pkg::EpochW-1:0] random_epoch();
    logic [esc_pkg::EpochW-1:0] v;
    case ($urandom_range(9))
      0, 1: begin
        // straddle a midnight, which lands on month and year ends now and then
        v = (($urandom / SecsPerDay) * SecsPerDay) - 32'd1 + $urandom_range(1);
      end
      2: v = $urandom_range(100_000_000);
      3: v = 32'hF000_0000 | $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      if (i == PhaseItems / 3) hold_toggle <= ~hold_toggle;
      send_epoch(random_epoch());
    end
  endtask

  initial begin
    din.valid         = 1'b0;
    din.epoch_seconds = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 34;
    rx_idle_pct = 69;
    send_epoch(32'd0);
    send_epoch(32'hFFFF_FFFF);
    send_epoch(32'd31535999);   // end of 1970
    send_epoch(32'd68169600);   // 1972-02-29
    send_epoch(32'd946684799);  // end of 1999
    send_epoch(32'd946684800);  // start of 2000
    send_epoch(32'd951782399);  // 2000-02-28 23:59:59
    send_epoch(32'd951782400);  // 2000-02-29
    send_epoch(32'd951868800);  // 2000-03-01
    send_epoch(32'd4102444799); // end of 2099
    send_epoch(32'd4102444800); // start of 2100
    send_epoch(32'd4107542399); // 2100-02-28 23:59:59, no leap day
    send_epoch(32'd4107542400); // 2100-03-01
    send_epoch(32'd4291747200); // start of 2106
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'h5555_5555);
    drain();

    run_phase(34, 69);
    drain();
    run_phase(69, 34);
    drain();
    run_phase(0, 0);
    drain();
    repeat (300) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
